/* sv/calibration_point_sequencer_core_defines.svh */
// Assertion macros shared by the calibration point sequencer modules
`ifndef CALIBRATION_POINT_SEQUENCER_CORE_DEFINES_SVH
`define CALIBRATION_POINT_SEQUENCER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low
`define CPS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define CPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/cps_pkg.sv */
// Types, constants and the target table of the calibration point sequencer
package cps_pkg;

    localparam int IN_W   = 136;
    localparam int OUT_W  = 88;
    localparam int MV_W   = 17;
    localparam int UA_W   = 32;
    localparam int VSUM_W = 25;
    localparam int CSUM_W = 40;
    localparam int VDIV_W = 26;
    localparam int DVR_W  = 8;
    localparam int CFG_W  = 16;

    localparam logic [15:0] SETTLE_RST = 16'd4000;
    localparam logic [15:0] WINDOW_RST = 16'd5000;
    localparam logic [7:0]  SPP_RST    = 8'd32;

    localparam logic [1:0] CFG_SETTLE = 2'd0;
    localparam logic [1:0] CFG_WINDOW = 2'd1;
    localparam logic [1:0] CFG_SPP    = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_SET    = 3'd1,
        PH_SETTLE = 3'd2,
        PH_SAMPLE = 3'd3,
        PH_FINISH = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_STORED  = 2'd1,
        EV_SKIPPED = 2'd2,
        EV_DONE    = 2'd3
    } t_event;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP,
        ST_DSTART,
        ST_DWAIT,
        ST_LOAD
    } t_ctrl_state;

    typedef struct packed {
        logic capture;
        logic step_en;
        logic div_start;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic out_free;
    } t_sts;

    localparam logic [15:0] TGT_A [8] = '{
        16'd5000, 16'd10000, 16'd15000, 16'd20000, 16'd0, 16'd0, 16'd0, 16'd0
    };
    localparam logic [15:0] TGT_B [8] = '{
        16'd5000, 16'd10000, 16'd15000, 16'd20000, 16'd30000, 16'd40000, 16'd0, 16'd0
    };

    function automatic logic [15:0] target_lookup(input logic ch, input logic [2:0] idx);
        return ch ? TGT_B[idx] : TGT_A[idx];
    endfunction

endpackage

/* sv/cps_div.sv */
// Restoring serial divider, one quotient bit per cycle, 8-bit divisor
module cps_div #(
    parameter int DW = 40
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [DW-1:0]               i_dividend,
    input  logic [cps_pkg::DVR_W-1:0]   i_divisor,
    output logic                        o_busy,
    output logic [DW-1:0]               o_quotient
);

    localparam int CW = $clog2(DW + 1);

    logic                      r_busy;
    logic [CW-1:0]             r_cnt;
    logic [DW-1:0]             r_q;
    logic [cps_pkg::DVR_W-1:0] r_rem;
    logic [cps_pkg::DVR_W-1:0] r_d;

    logic [cps_pkg::DVR_W:0]   trial;
    logic [cps_pkg::DVR_W:0]   diff;
    logic                      ge;

    assign trial = {r_rem, r_q[DW-1]};
    assign ge    = trial >= {1'b0, r_d};
    assign diff  = trial - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(DW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_d   <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[DW-2:0], ge};
            r_rem <= ge ? diff[cps_pkg::DVR_W-1:0] : trial[cps_pkg::DVR_W-1:0];
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_q;

endmodule

/* sv/cps_ctrl.sv */
// Controller state machine: accept, step, divide, load result
`include "calibration_point_sequencer_core_defines.svh"

module cps_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_tvalid,
    output logic            o_in_tready,
    input  cps_pkg::t_sts   i_sts,
    output cps_pkg::t_cmd   o_cmd
);

    cps_pkg::t_ctrl_state r_state;
    cps_pkg::t_ctrl_state n_state;
    logic                 accept;

    assign accept = i_in_tvalid && o_in_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cps_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cps_pkg::ST_IDLE:   if (i_in_tvalid) n_state = cps_pkg::ST_STEP;
            cps_pkg::ST_STEP:   n_state = cps_pkg::ST_DSTART;
            cps_pkg::ST_DSTART: n_state = cps_pkg::ST_DWAIT;
            cps_pkg::ST_DWAIT:  if (!i_sts.div_busy) n_state = cps_pkg::ST_LOAD;
            cps_pkg::ST_LOAD:   if (i_sts.out_free) n_state = cps_pkg::ST_IDLE;
            default:            n_state = cps_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_tready = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            cps_pkg::ST_IDLE: begin
                o_in_tready   = 1'b1;
                o_cmd.capture = i_in_tvalid;
            end
            cps_pkg::ST_STEP:   o_cmd.step_en   = 1'b1;
            cps_pkg::ST_DSTART: o_cmd.div_start = 1'b1;
            cps_pkg::ST_DWAIT:  o_cmd           = '0;
            cps_pkg::ST_LOAD:   o_cmd.load_out  = i_sts.out_free;
            default:            o_cmd           = '0;
        endcase
    end

    `CPS_ASSERT_NEXT(a_accept_step, i_clk, i_rst_n, accept, r_state == cps_pkg::ST_STEP, "accepted beat not stepped")
    `CPS_ASSERT_SAME(a_load_free, i_clk, i_rst_n, o_cmd.load_out, i_sts.out_free, "result loaded over a pending beat")
    `CPS_ASSERT_SAME(a_start_idle_div, i_clk, i_rst_n, o_cmd.div_start, !i_sts.div_busy, "divider restarted while busy")

endmodule

/* sv/cps_dp.sv */
// Datapath: sequencer registers, sample sums, mean dividers and output register
`include "calibration_point_sequencer_core_defines.svh"

module cps_dp #(
    parameter int POINTS_A = 4,
    parameter int POINTS_B = 6
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cps_pkg::t_cmd                 i_cmd,
    output cps_pkg::t_sts                 o_sts,
    input  logic                          i_cfg_valid,
    input  logic [1:0]                    i_cfg_index,
    input  logic [cps_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic [cps_pkg::IN_W-1:0]      i_in_tdata,
    output logic                          o_out_tvalid,
    input  logic                          i_out_tready,
    output logic [cps_pkg::OUT_W-1:0]     o_out_tdata
);

    localparam logic [3:0] CNT_A = 4'(POINTS_A);
    localparam logic [3:0] CNT_B = 4'(POINTS_B);

    // configuration
    logic [15:0] r_settle;
    logic [15:0] r_window;
    logic [7:0]  r_spp;

    // sequencer state
    cps_pkg::t_phase            r_phase, n_phase;
    logic                       r_ch, n_ch;
    logic [2:0]                 r_idx, n_idx;
    logic [31:0]                r_start_ms, n_start_ms;
    logic [cps_pkg::VSUM_W-1:0] r_vsum, n_vsum;
    logic [cps_pkg::CSUM_W-1:0] r_csum, n_csum;
    logic [7:0]                 r_cnt, n_cnt;

    // report of the last step
    logic            r_rep_ch, n_rep_ch;
    logic [2:0]      r_rep_idx, n_rep_idx;
    logic [15:0]     r_tgt, n_tgt;
    cps_pkg::t_event r_event, n_event;

    logic [cps_pkg::IN_W-1:0]  r_in;
    logic [cps_pkg::OUT_W-1:0] r_out_tdata;
    logic                      r_out_valid;

    // unpacked input beat
    logic [31:0]               in_now;
    logic                      in_start;
    logic                      in_valid_a, in_valid_b;
    logic [cps_pkg::MV_W-1:0]  in_mv_a, in_mv_b;
    logic [cps_pkg::UA_W-1:0]  in_ua_a, in_ua_b;

    // step logic
    cps_pkg::t_phase           ph0;
    logic                      ch0;
    logic [2:0]                idx0;
    logic [31:0]               elapsed;
    logic [7:0]                need;
    logic [16:0]               window_end;
    logic                      smp_valid;
    logic [cps_pkg::MV_W-1:0]  smp_mv;
    logic [cps_pkg::UA_W-1:0]  smp_ua;
    logic                      add_ok;
    logic [7:0]                cnt_inc;
    logic [7:0]                cnt_s;
    logic                      advance;
    logic                      last_in_ch;
    logic                      pt_done;

    // divider side
    logic [cps_pkg::VDIV_W-1:0] vdividend;
    logic [cps_pkg::CSUM_W-1:0] cmag;
    logic [cps_pkg::VDIV_W-1:0] vquo;
    logic [cps_pkg::CSUM_W-1:0] cquo;
    logic [cps_pkg::CSUM_W-1:0] cquo_s;
    logic                       vbusy, cbusy;
    logic [cps_pkg::MV_W-1:0]   mean_mv;
    logic [cps_pkg::UA_W-1:0]   mean_ua;

    assign in_now     = r_in[31:0];
    assign in_start   = r_in[32];
    assign in_valid_a = r_in[33];
    assign in_mv_a    = r_in[50:34];
    assign in_ua_a    = r_in[82:51];
    assign in_valid_b = r_in[83];
    assign in_mv_b    = r_in[100:84];
    assign in_ua_b    = r_in[132:101];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle <= cps_pkg::SETTLE_RST;
            r_window <= cps_pkg::WINDOW_RST;
            r_spp    <= cps_pkg::SPP_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                cps_pkg::CFG_SETTLE: r_settle <= i_cfg_data;
                cps_pkg::CFG_WINDOW: r_window <= i_cfg_data;
                cps_pkg::CFG_SPP:    r_spp    <= i_cfg_data[7:0];
                default:             r_spp    <= r_spp;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in <= i_in_tdata;
        end
    end

    always_comb begin
        ph0        = (r_phase == cps_pkg::PH_IDLE && in_start) ? cps_pkg::PH_SET : r_phase;
        ch0        = (r_phase == cps_pkg::PH_IDLE && in_start) ? 1'b0 : r_ch;
        idx0       = (r_phase == cps_pkg::PH_IDLE && in_start) ? 3'd0 : r_idx;
        elapsed    = in_now - r_start_ms;
        need       = (r_spp == 8'd0) ? 8'd1 : r_spp;
        window_end = {1'b0, r_settle} + {1'b0, r_window};
        smp_valid  = ch0 ? in_valid_b : in_valid_a;
        smp_mv     = ch0 ? in_mv_b : in_mv_a;
        smp_ua     = ch0 ? in_ua_b : in_ua_a;
        add_ok     = smp_valid && (r_cnt != 8'hFF);
        cnt_inc    = r_cnt + 8'd1;
        cnt_s      = add_ok ? cnt_inc : r_cnt;
        last_in_ch = ({1'b0, idx0} + 4'd1) >= (ch0 ? CNT_B : CNT_A);

        n_phase    = ph0;
        n_ch       = ch0;
        n_idx      = idx0;
        n_start_ms = r_start_ms;
        n_vsum     = r_vsum;
        n_csum     = r_csum;
        n_cnt      = r_cnt;
        n_event    = cps_pkg::EV_NONE;
        advance    = 1'b0;

        unique case (ph0)
            cps_pkg::PH_SET: begin
                n_start_ms = in_now;
                n_vsum     = '0;
                n_csum     = '0;
                n_cnt      = '0;
                n_phase    = cps_pkg::PH_SETTLE;
            end
            cps_pkg::PH_SETTLE: begin
                if (elapsed >= {16'd0, r_settle}) n_phase = cps_pkg::PH_SAMPLE;
            end
            cps_pkg::PH_SAMPLE: begin
                if (add_ok) begin
                    n_vsum = r_vsum + cps_pkg::VSUM_W'(smp_mv);
                    n_csum = r_csum + {{(cps_pkg::CSUM_W - cps_pkg::UA_W){smp_ua[31]}}, smp_ua};
                    n_cnt  = cnt_inc;
                end
                if (cnt_s >= need) begin
                    n_event = cps_pkg::EV_STORED;
                    advance = 1'b1;
                end else if (elapsed >= {15'd0, window_end}) begin
                    n_event = cps_pkg::EV_SKIPPED;
                    advance = 1'b1;
                end
            end
            cps_pkg::PH_FINISH: begin
                n_phase = cps_pkg::PH_IDLE;
                n_event = cps_pkg::EV_DONE;
            end
            default: n_phase = ph0;
        endcase

        if (advance) begin
            priority if (!last_in_ch) begin
                n_idx   = idx0 + 3'd1;
                n_phase = cps_pkg::PH_SET;
            end else if (!ch0) begin
                n_ch    = 1'b1;
                n_idx   = 3'd0;
                n_phase = cps_pkg::PH_SET;
            end else begin
                n_phase = cps_pkg::PH_FINISH;
            end
        end

        // a stored or skipped point reports itself, not the point that follows
        pt_done   = (n_event == cps_pkg::EV_STORED) || (n_event == cps_pkg::EV_SKIPPED);
        n_rep_ch  = pt_done ? ch0 : n_ch;
        n_rep_idx = pt_done ? idx0 : n_idx;
        n_tgt     = (n_phase == cps_pkg::PH_IDLE && !pt_done) ? 16'd0
                    : cps_pkg::target_lookup(n_rep_ch, n_rep_idx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= cps_pkg::PH_IDLE;
            r_ch       <= 1'b0;
            r_idx      <= '0;
            r_start_ms <= '0;
            r_vsum     <= '0;
            r_csum     <= '0;
            r_cnt      <= '0;
        end else if (i_cmd.step_en) begin
            r_phase    <= n_phase;
            r_ch       <= n_ch;
            r_idx      <= n_idx;
            r_start_ms <= n_start_ms;
            r_vsum     <= n_vsum;
            r_csum     <= n_csum;
            r_cnt      <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step_en) begin
            r_rep_ch  <= n_rep_ch;
            r_rep_idx <= n_rep_idx;
            r_tgt     <= n_tgt;
            r_event   <= n_event;
        end
    end

    // round the voltage mean by adding half the count; divide the current magnitude
    assign vdividend = {1'b0, r_vsum} + cps_pkg::VDIV_W'(r_cnt[7:1]);
    assign cmag      = r_csum[cps_pkg::CSUM_W-1] ? (~r_csum + cps_pkg::CSUM_W'(1)) : r_csum;

    cps_div #(.DW(cps_pkg::VDIV_W)) u_vdiv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (vdividend),
        .i_divisor  (r_cnt),
        .o_busy     (vbusy),
        .o_quotient (vquo)
    );

    cps_div #(.DW(cps_pkg::CSUM_W)) u_cdiv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (cmag),
        .i_divisor  (r_cnt),
        .o_busy     (cbusy),
        .o_quotient (cquo)
    );

    assign cquo_s  = r_csum[cps_pkg::CSUM_W-1] ? (~cquo + cps_pkg::CSUM_W'(1)) : cquo;
    assign mean_mv = (r_cnt == 8'd0) ? '0 : vquo[cps_pkg::MV_W-1:0];
    assign mean_ua = (r_cnt == 8'd0) ? '0 : cquo_s[cps_pkg::UA_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_tdata <= {5'd0, r_cnt, mean_ua, mean_mv, r_event, r_tgt, r_rep_idx,
                            r_rep_ch, r_phase, (r_phase != cps_pkg::PH_IDLE)};
        end
    end

    assign o_sts.div_busy = vbusy || cbusy;
    assign o_sts.out_free = !r_out_valid || i_out_tready;
    assign o_out_tvalid   = r_out_valid;
    assign o_out_tdata    = r_out_tdata;

    `CPS_ASSERT_NEXT(a_cnt_hold, i_clk, i_rst_n, !i_cmd.step_en, $stable(r_cnt), "sample count moved outside a step")
    `CPS_ASSERT_NEXT(a_div_runs, i_clk, i_rst_n, i_cmd.div_start, o_sts.div_busy, "divider did not start")
    `CPS_ASSERT_NEXT(a_out_loaded, i_clk, i_rst_n, i_cmd.load_out, r_out_valid, "loaded result not presented")

endmodule

/* sv/calibration_point_sequencer_core.sv */
// An accepted input beat is captured, stepped, divided and loaded as a result beat while
// the output register is free; a result held there delays the next load until it drains. A new
// beat is taken only once the previous one has passed the 40-step serial divider for the current
// mean (the voltage mean divider needs 26 steps) and been loaded; a beat is taken while the
// previous result still waits. Reset (i_rst_n low, synchronous) clears the sequencer to
// idle on channel A and restores settle 4000 ms, window 5000 ms and 32 samples per point.
module calibration_point_sequencer_core #(
    parameter int POINTS_A = 4,
    parameter int POINTS_B = 6
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // now_ms[31:0], start_request[32], valid_a[33], bus_mv_a[50:34],
    // current_ua_a[82:51], valid_b[83], bus_mv_b[100:84], current_ua_b[132:101], zeros
    input  logic [cps_pkg::IN_W-1:0]   s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // running[0], phase[3:1], on_channel_b[4], point_index[7:5], setpoint_mv[23:8],
    // event_code[25:24], mean_mv[42:26], mean_current_ua[74:43], samples_taken[82:75], zeros
    output logic [cps_pkg::OUT_W-1:0]  m_axis_tdata,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [1:0]                 i_cfg_index,
    input  logic [cps_pkg::CFG_W-1:0]  i_cfg_data
);

    cps_pkg::t_cmd cmd;
    cps_pkg::t_sts sts;

    // registers take a write in any cycle
    assign o_cfg_ready = 1'b1;

    cps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_tvalid (s_axis_tvalid),
        .o_in_tready (s_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    cps_dp #(
        .POINTS_A (POINTS_A),
        .POINTS_B (POINTS_B)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_tdata   (s_axis_tdata),
        .o_out_tvalid (m_axis_tvalid),
        .i_out_tready (m_axis_tready),
        .o_out_tdata  (m_axis_tdata)
    );

endmodule
